[rtl/nfca_pkg.sv]
`timescale 1ns / 1ps

package nfca_pkg;

	// Descriptor table geometry
	localparam int NUM_DESC   = 64;
	localparam int ADDR_W     = $clog2(NUM_DESC);
	localparam int IDX_W      = $clog2(NUM_DESC + 2);
	localparam int WALK_LIMIT = 2 * NUM_DESC + 4;
	localparam int CNT_W      = $clog2(WALK_LIMIT + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Null link and the free-list head pseudo index
	localparam idx_t NIL   = IDX_W'(NUM_DESC);
	localparam idx_t HEADP = IDX_W'(NUM_DESC + 1);
	localparam cnt_t LIMIT = CNT_W'(WALK_LIMIT);

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	// Request codes
	localparam logic [1:0] ACT_INIT   = 2'd0;
	localparam logic [1:0] ACT_ALLOC  = 2'd1;
	localparam logic [1:0] ACT_FREE   = 2'd2;
	localparam logic [1:0] ACT_SHRINK = 2'd3;

	// Result status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_NOBLK = 2'd1;
	localparam logic [1:0] STS_GROW  = 2'd2;
	localparam logic [1:0] STS_NOFIT = 2'd3;

	// Register indexes
	localparam logic REG_POOL_START  = 1'b0;
	localparam logic REG_POOL_LENGTH = 1'b1;

	// Write controls for the descriptor table, one port per field array
	typedef struct packed {
		logic              start_we;
		logic              len_we;
		logic              next_we;
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] len_addr;
		logic [ADDR_W-1:0] next_addr;
		logic [31:0]       start_data;
		logic [31:0]       len_data;
		idx_t              next_data;
	} desc_wr_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_A_PREP,
		ST_A_ROV,
		ST_A_HEAD,
		ST_A_EVAL,
		ST_A_SPLIT,
		ST_A_LINK,
		ST_A_USE,
		ST_A_END,
		ST_T_REQ,
		ST_T_WAIT,
		ST_F_START,
		ST_F_HEAD,
		ST_F_EVAL,
		ST_F_UNLINK,
		ST_S_CHECK,
		ST_S_REM,
		ST_S_SPLIT,
		ST_S_LEN,
		ST_I_START,
		ST_I_HEAD,
		ST_I_EVAL,
		ST_I_LINK,
		ST_I_LINK2,
		ST_I_M1,
		ST_I_M1R,
		ST_I_M2,
		ST_I_M2E,
		ST_I_M2A,
		ST_I_M2R
	} state_t;

	function automatic logic is_desc(idx_t d);
		return d < IDX_W'(NUM_DESC);
	endfunction

endpackage

[rtl/nfca_desc_mem.sv]
`timescale 1ns / 1ps

// Descriptor table: start, length and link arrays, one write port each,
// one shared registered read port.
module nfca_desc_mem (
	input  logic                          clk,
	input  nfca_pkg::desc_wr_t            wr,
	input  logic                          rd_en,
	input  logic [nfca_pkg::ADDR_W-1:0]   rd_addr,
	output logic [31:0]                   rd_start,
	output logic [31:0]                   rd_len,
	output nfca_pkg::idx_t                rd_next
);

	logic [31:0]    start_mem [nfca_pkg::NUM_DESC];
	logic [31:0]    len_mem   [nfca_pkg::NUM_DESC];
	nfca_pkg::idx_t next_mem  [nfca_pkg::NUM_DESC];

	// Writes
	always_ff @(posedge clk) begin
		if (wr.start_we) begin
			start_mem[wr.start_addr] <= wr.start_data;
		end
		if (wr.len_we) begin
			len_mem[wr.len_addr] <= wr.len_data;
		end
		if (wr.next_we) begin
			next_mem[wr.next_addr] <= wr.next_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_start <= start_mem[rd_addr];
			rd_len   <= len_mem[rd_addr];
			rd_next  <= next_mem[rd_addr];
		end
	end

endmodule

[rtl/next_fit_coalescing_allocator.sv]
`timescale 1ns / 1ps

// Next-fit free-list allocator with coalescing over a 64-entry descriptor
// table. Requests arrive on the input channel (in_valid/in_stall with
// action, block_address, request_length); each produces exactly one result
// transaction (out_valid/out_stall with result_value, status).
// action: init pool, allocate, free, shrink. pool_start/pool_length are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, and the block itself does not enforce it.
// One request is worked at a time. For init and for allocate with no rover,
// the result is registered from the INIT or A_PREP state after acceptance.
// Each descriptor visited on a list walk costs a table read and an
// evaluation; the used and free lists share the 64 descriptors, and walks
// also stop at 132 steps. Free and shrink walk the used list and then the
// free list, with split, link and merge steps. The next request is accepted
// in the cycle after the result is taken. A single 32-bit adder/subtractor
// handles all rounding, fit tests, splits and merges under the sequencer.
// in_stall is high while a request is being worked and while a result is
// held for the receiver. A stalled result holds its value until taken.
// Reset empties all lists; the table contents stay undefined until init.
module next_fit_coalescing_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] block_address,
	input  logic [31:0] request_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic [1:0]  status
);

	nfca_pkg::state_t state_q, state_d;

	// Control state
	nfca_pkg::idx_t   free_head_q, used_head_q, rover_q, spare_head_q;
	nfca_pkg::idx_t   fresh_count_q;
	logic [31:0]      pool_start_q;
	logic [30:0]      pool_len_q;
	logic             out_valid_q;

	// Working registers
	logic [1:0]       op_q;
	logic [31:0]      addr_q, req_q, amt_q, rem_q, largest_q;
	logic             report_q, exact_q;
	nfca_pkg::idx_t   prv_q, blk_q, link_q, r_q, d_q, ins_next_q;
	nfca_pkg::cnt_t   cnt_q;
	logic [31:0]      blk_start_q, blk_len_q;
	nfca_pkg::idx_t   blk_next_q;
	logic [31:0]      ins_start_q, ins_len_q, ins_end_q, pl_q;
	logic [31:0]      res_q;
	logic [1:0]       sts_q;

	// Table port
	nfca_pkg::desc_wr_t wr;
	logic               rd_en;
	nfca_pkg::idx_t     rd_idx;
	logic [31:0]        rd_start, rd_len;
	nfca_pkg::idx_t     rd_next;

	// Shared adder/subtractor
	logic [31:0]        alu_a, alu_b;
	nfca_pkg::alu_op_t  alu_op;
	logic [32:0]        alu_res;

	// Completion
	logic               fin;
	logic [31:0]        fin_res;
	logic [1:0]         fin_sts;

	logic               in_acc, report_c, a_fit, f_match, grow, adj1;
	nfca_pkg::idx_t     a_cur;

	nfca_desc_mem u_mem (
		.clk      (clk),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_idx[nfca_pkg::ADDR_W-1:0]),
		.rd_start (rd_start),
		.rd_len   (rd_len),
		.rd_next  (rd_next)
	);

	assign alu_res = (alu_op == nfca_pkg::ALU_SUB) ? ({1'b0, alu_a} - {1'b0, alu_b})
	                                               : ({1'b0, alu_a} + {1'b0, alu_b});

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != nfca_pkg::ST_IDLE) || out_valid_q;
	assign report_c = (req_q == nfca_pkg::ALL_ONES);
	assign a_fit    = !report_q && !alu_res[32];
	assign f_match  = (rd_start == addr_q);
	assign grow     = $signed(blk_len_q) < $signed(req_q);
	assign adj1     = (ins_end_q == rd_start);
	assign a_cur    = nfca_pkg::is_desc(blk_q) ? blk_q : free_head_q;

	assign out_valid    = out_valid_q;
	assign result_value = res_q;
	assign status       = sts_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nfca_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (action)
						nfca_pkg::ACT_INIT:  state_d = nfca_pkg::ST_INIT;
						nfca_pkg::ACT_ALLOC: state_d = nfca_pkg::ST_A_PREP;
						default:             state_d = nfca_pkg::ST_F_START;
					endcase
				end
			end
			nfca_pkg::ST_INIT:   state_d = nfca_pkg::ST_IDLE;
			nfca_pkg::ST_A_PREP: state_d = nfca_pkg::is_desc(rover_q) ? nfca_pkg::ST_A_ROV
			                                                          : nfca_pkg::ST_IDLE;
			nfca_pkg::ST_A_ROV:  state_d = nfca_pkg::ST_A_HEAD;
			nfca_pkg::ST_A_HEAD: state_d = nfca_pkg::is_desc(a_cur) ? nfca_pkg::ST_A_EVAL
			                                                        : nfca_pkg::ST_A_END;
			nfca_pkg::ST_A_EVAL: begin
				if (a_fit) begin
					state_d = (alu_res[31:0] == '0) ? nfca_pkg::ST_A_LINK : nfca_pkg::ST_T_REQ;
				end else if (blk_q == rover_q || cnt_q == nfca_pkg::LIMIT - 1'b1) begin
					state_d = nfca_pkg::ST_A_END;
				end else begin
					state_d = nfca_pkg::ST_A_HEAD;
				end
			end
			nfca_pkg::ST_A_SPLIT: state_d = nfca_pkg::ST_A_LINK;
			nfca_pkg::ST_A_LINK:  state_d = nfca_pkg::ST_A_USE;
			nfca_pkg::ST_A_USE:   state_d = nfca_pkg::ST_IDLE;
			nfca_pkg::ST_A_END:   state_d = nfca_pkg::ST_IDLE;
			nfca_pkg::ST_T_REQ: begin
				if (nfca_pkg::is_desc(spare_head_q)) begin
					state_d = nfca_pkg::ST_T_WAIT;
				end else if (fresh_count_q != nfca_pkg::NIL) begin
					state_d = (op_q == nfca_pkg::ACT_ALLOC) ? nfca_pkg::ST_A_SPLIT
					                                        : nfca_pkg::ST_S_SPLIT;
				end else begin
					state_d = nfca_pkg::ST_IDLE;
				end
			end
			nfca_pkg::ST_T_WAIT: state_d = (op_q == nfca_pkg::ACT_ALLOC) ? nfca_pkg::ST_A_SPLIT
			                                                             : nfca_pkg::ST_S_SPLIT;
			nfca_pkg::ST_F_START: state_d = nfca_pkg::ST_F_HEAD;
			nfca_pkg::ST_F_HEAD: begin
				if (!nfca_pkg::is_desc(blk_q) || cnt_q == nfca_pkg::LIMIT) begin
					state_d = nfca_pkg::ST_IDLE;
				end else begin
					state_d = nfca_pkg::ST_F_EVAL;
				end
			end
			nfca_pkg::ST_F_EVAL: begin
				if (!f_match) begin
					state_d = nfca_pkg::ST_F_HEAD;
				end else if (op_q == nfca_pkg::ACT_FREE) begin
					state_d = nfca_pkg::ST_F_UNLINK;
				end else begin
					state_d = nfca_pkg::ST_S_CHECK;
				end
			end
			nfca_pkg::ST_F_UNLINK: state_d = nfca_pkg::ST_I_START;
			nfca_pkg::ST_S_CHECK:  state_d = grow ? nfca_pkg::ST_IDLE : nfca_pkg::ST_S_REM;
			nfca_pkg::ST_S_REM:    state_d = nfca_pkg::ST_T_REQ;
			nfca_pkg::ST_S_SPLIT:  state_d = nfca_pkg::ST_S_LEN;
			nfca_pkg::ST_S_LEN:    state_d = nfca_pkg::ST_I_START;
			nfca_pkg::ST_I_START:  state_d = nfca_pkg::ST_I_HEAD;
			nfca_pkg::ST_I_HEAD: begin
				if (!nfca_pkg::is_desc(blk_q) || cnt_q == nfca_pkg::LIMIT) begin
					state_d = nfca_pkg::ST_I_LINK;
				end else begin
					state_d = nfca_pkg::ST_I_EVAL;
				end
			end
			nfca_pkg::ST_I_EVAL:  state_d = alu_res[32] ? nfca_pkg::ST_I_HEAD : nfca_pkg::ST_I_LINK;
			nfca_pkg::ST_I_LINK:  state_d = nfca_pkg::ST_I_LINK2;
			nfca_pkg::ST_I_LINK2: state_d = nfca_pkg::is_desc(blk_q) ? nfca_pkg::ST_I_M1
			                                                         : nfca_pkg::ST_I_M2;
			nfca_pkg::ST_I_M1:    state_d = adj1 ? nfca_pkg::ST_I_M1R : nfca_pkg::ST_I_M2;
			nfca_pkg::ST_I_M1R:   state_d = nfca_pkg::ST_I_M2;
			nfca_pkg::ST_I_M2:    state_d = nfca_pkg::is_desc(prv_q) ? nfca_pkg::ST_I_M2E
			                                                         : nfca_pkg::ST_IDLE;
			nfca_pkg::ST_I_M2E:   state_d = (alu_res[31:0] == ins_start_q) ? nfca_pkg::ST_I_M2A
			                                                               : nfca_pkg::ST_IDLE;
			nfca_pkg::ST_I_M2A:   state_d = nfca_pkg::ST_I_M2R;
			nfca_pkg::ST_I_M2R:   state_d = nfca_pkg::ST_IDLE;
			default:              state_d = nfca_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: table port, adder operands, completion
	always_comb begin
		wr      = '0;
		rd_en   = 1'b0;
		rd_idx  = '0;
		alu_a   = '0;
		alu_b   = '0;
		alu_op  = nfca_pkg::ALU_ADD;
		fin     = 1'b0;
		fin_res = '0;
		fin_sts = nfca_pkg::STS_OK;
		case (state_q)
			nfca_pkg::ST_INIT: begin
				wr.start_we   = 1'b1;
				wr.len_we     = 1'b1;
				wr.next_we    = 1'b1;
				wr.start_data = pool_start_q;
				wr.len_data   = {1'b0, pool_len_q};
				wr.next_data  = nfca_pkg::NIL;
				fin           = 1'b1;
			end
			nfca_pkg::ST_A_PREP: begin
				// round odd sizes up to even
				alu_a  = req_q;
				alu_b  = {31'b0, req_q[0] & !report_c};
				rd_en  = nfca_pkg::is_desc(rover_q);
				rd_idx = rover_q;
				if (!nfca_pkg::is_desc(rover_q)) begin
					fin     = 1'b1;
					fin_sts = report_c ? nfca_pkg::STS_OK : nfca_pkg::STS_NOFIT;
				end
			end
			nfca_pkg::ST_A_HEAD: begin
				rd_en  = nfca_pkg::is_desc(a_cur);
				rd_idx = a_cur;
			end
			nfca_pkg::ST_A_EVAL: begin
				alu_a  = rd_len;
				alu_b  = amt_q;
				alu_op = nfca_pkg::ALU_SUB;
			end
			nfca_pkg::ST_T_REQ: begin
				rd_en  = nfca_pkg::is_desc(spare_head_q);
				rd_idx = spare_head_q;
				if (!nfca_pkg::is_desc(spare_head_q) && fresh_count_q == nfca_pkg::NIL) begin
					fin     = 1'b1;
					fin_sts = nfca_pkg::STS_NOFIT;
				end
			end
			nfca_pkg::ST_A_SPLIT: begin
				// remainder descriptor takes the high part
				alu_a         = blk_start_q;
				alu_b         = amt_q;
				wr.start_we   = 1'b1;
				wr.len_we     = 1'b1;
				wr.next_we    = 1'b1;
				wr.start_addr = r_q[nfca_pkg::ADDR_W-1:0];
				wr.len_addr   = r_q[nfca_pkg::ADDR_W-1:0];
				wr.next_addr  = r_q[nfca_pkg::ADDR_W-1:0];
				wr.start_data = alu_res[31:0];
				wr.len_data   = rem_q;
				wr.next_data  = blk_next_q;
			end
			nfca_pkg::ST_A_LINK: begin
				wr.next_we   = nfca_pkg::is_desc(prv_q);
				wr.next_addr = prv_q[nfca_pkg::ADDR_W-1:0];
				wr.next_data = link_q;
				wr.len_we    = !exact_q;
				wr.len_addr  = blk_q[nfca_pkg::ADDR_W-1:0];
				wr.len_data  = amt_q;
			end
			nfca_pkg::ST_A_USE: begin
				wr.next_we   = 1'b1;
				wr.next_addr = blk_q[nfca_pkg::ADDR_W-1:0];
				wr.next_data = used_head_q;
				fin          = 1'b1;
				fin_res      = blk_start_q;
			end
			nfca_pkg::ST_A_END: begin
				fin     = 1'b1;
				fin_res = report_q ? largest_q : 32'd0;
				fin_sts = report_q ? nfca_pkg::STS_OK : nfca_pkg::STS_NOFIT;
			end
			nfca_pkg::ST_F_HEAD: begin
				if (!nfca_pkg::is_desc(blk_q) || cnt_q == nfca_pkg::LIMIT) begin
					fin     = 1'b1;
					fin_sts = nfca_pkg::STS_NOBLK;
				end else begin
					rd_en  = 1'b1;
					rd_idx = blk_q;
				end
			end
			nfca_pkg::ST_F_UNLINK: begin
				wr.next_we   = nfca_pkg::is_desc(prv_q);
				wr.next_addr = prv_q[nfca_pkg::ADDR_W-1:0];
				wr.next_data = blk_next_q;
			end
			nfca_pkg::ST_S_CHECK: begin
				alu_a = req_q;
				alu_b = {31'b0, req_q[0]};
				if (grow) begin
					fin     = 1'b1;
					fin_sts = nfca_pkg::STS_GROW;
				end
			end
			nfca_pkg::ST_S_REM: begin
				alu_a  = blk_len_q;
				alu_b  = amt_q;
				alu_op = nfca_pkg::ALU_SUB;
			end
			nfca_pkg::ST_S_SPLIT: begin
				alu_a         = blk_start_q;
				alu_b         = amt_q;
				wr.start_we   = 1'b1;
				wr.len_we     = 1'b1;
				wr.start_addr = r_q[nfca_pkg::ADDR_W-1:0];
				wr.len_addr   = r_q[nfca_pkg::ADDR_W-1:0];
				wr.start_data = alu_res[31:0];
				wr.len_data   = rem_q;
			end
			nfca_pkg::ST_S_LEN: begin
				wr.len_we   = 1'b1;
				wr.len_addr = blk_q[nfca_pkg::ADDR_W-1:0];
				wr.len_data = amt_q;
			end
			nfca_pkg::ST_I_START: begin
				alu_a = ins_start_q;
				alu_b = ins_len_q;
			end
			nfca_pkg::ST_I_HEAD: begin
				rd_en  = nfca_pkg::is_desc(blk_q) && cnt_q != nfca_pkg::LIMIT;
				rd_idx = blk_q;
			end
			nfca_pkg::ST_I_EVAL: begin
				// borrow set when the walked block starts below the new one
				alu_a  = rd_start;
				alu_b  = ins_start_q;
				alu_op = nfca_pkg::ALU_SUB;
			end
			nfca_pkg::ST_I_LINK: begin
				wr.next_we   = 1'b1;
				wr.next_addr = d_q[nfca_pkg::ADDR_W-1:0];
				wr.next_data = blk_q;
			end
			nfca_pkg::ST_I_LINK2: begin
				wr.next_we   = nfca_pkg::is_desc(prv_q);
				wr.next_addr = prv_q[nfca_pkg::ADDR_W-1:0];
				wr.next_data = d_q;
				rd_en        = nfca_pkg::is_desc(blk_q);
				rd_idx       = blk_q;
			end
			nfca_pkg::ST_I_M1: begin
				// forward merge into the inserted block
				alu_a        = ins_len_q;
				alu_b        = rd_len;
				wr.len_we    = adj1;
				wr.next_we   = adj1;
				wr.len_addr  = d_q[nfca_pkg::ADDR_W-1:0];
				wr.next_addr = d_q[nfca_pkg::ADDR_W-1:0];
				wr.len_data  = alu_res[31:0];
				wr.next_data = rd_next;
			end
			nfca_pkg::ST_I_M1R: begin
				wr.next_we   = 1'b1;
				wr.next_addr = blk_q[nfca_pkg::ADDR_W-1:0];
				wr.next_data = spare_head_q;
			end
			nfca_pkg::ST_I_M2: begin
				rd_en  = nfca_pkg::is_desc(prv_q);
				rd_idx = prv_q;
				fin    = !nfca_pkg::is_desc(prv_q);
			end
			nfca_pkg::ST_I_M2E: begin
				alu_a = rd_start;
				alu_b = rd_len;
				fin   = (alu_res[31:0] != ins_start_q);
			end
			nfca_pkg::ST_I_M2A: begin
				// backward merge into the predecessor
				alu_a        = pl_q;
				alu_b        = ins_len_q;
				wr.len_we    = 1'b1;
				wr.next_we   = 1'b1;
				wr.len_addr  = prv_q[nfca_pkg::ADDR_W-1:0];
				wr.next_addr = prv_q[nfca_pkg::ADDR_W-1:0];
				wr.len_data  = alu_res[31:0];
				wr.next_data = ins_next_q;
			end
			nfca_pkg::ST_I_M2R: begin
				wr.next_we   = 1'b1;
				wr.next_addr = d_q[nfca_pkg::ADDR_W-1:0];
				wr.next_data = spare_head_q;
				fin          = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control state: sequencer, list heads, rover, descriptor source, pool registers, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= nfca_pkg::ST_IDLE;
			free_head_q   <= nfca_pkg::NIL;
			used_head_q   <= nfca_pkg::NIL;
			rover_q       <= nfca_pkg::NIL;
			spare_head_q  <= nfca_pkg::NIL;
			fresh_count_q <= '0;
			pool_start_q  <= '0;
			pool_len_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == nfca_pkg::REG_POOL_START) begin
					pool_start_q <= cfg_data;
				end else begin
					pool_len_q <= cfg_data[30:0];
				end
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				nfca_pkg::ST_INIT: begin
					free_head_q   <= '0;
					used_head_q   <= nfca_pkg::NIL;
					rover_q       <= '0;
					spare_head_q  <= nfca_pkg::NIL;
					fresh_count_q <= nfca_pkg::IDX_W'(1);
				end
				nfca_pkg::ST_T_REQ: begin
					if (!nfca_pkg::is_desc(spare_head_q) && fresh_count_q != nfca_pkg::NIL) begin
						fresh_count_q <= fresh_count_q + 1'b1;
					end
				end
				nfca_pkg::ST_T_WAIT: spare_head_q <= rd_next;
				nfca_pkg::ST_A_LINK: begin
					if (prv_q == nfca_pkg::HEADP) begin
						free_head_q <= link_q;
					end
				end
				nfca_pkg::ST_A_USE: begin
					used_head_q <= blk_q;
					rover_q     <= (prv_q == nfca_pkg::HEADP) ? free_head_q : prv_q;
				end
				nfca_pkg::ST_F_UNLINK: begin
					if (!nfca_pkg::is_desc(prv_q)) begin
						used_head_q <= blk_next_q;
					end
				end
				nfca_pkg::ST_I_LINK2: begin
					if (!nfca_pkg::is_desc(prv_q)) begin
						free_head_q <= d_q;
					end
					if (!nfca_pkg::is_desc(rover_q)) begin
						rover_q <= d_q;
					end
				end
				nfca_pkg::ST_I_M1: begin
					if (adj1 && rover_q == blk_q) begin
						rover_q <= d_q;
					end
				end
				nfca_pkg::ST_I_M1R: spare_head_q <= blk_q;
				nfca_pkg::ST_I_M2A: begin
					if (rover_q == d_q) begin
						rover_q <= prv_q;
					end
				end
				nfca_pkg::ST_I_M2R: spare_head_q <= d_q;
				default: begin
				end
			endcase
		end
	end

	// Working registers of the current transaction
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= fin_res;
			sts_q <= fin_sts;
		end
		case (state_q)
			nfca_pkg::ST_IDLE: begin
				if (in_acc) begin
					op_q   <= action;
					addr_q <= block_address;
					req_q  <= request_length;
				end
			end
			nfca_pkg::ST_A_PREP: begin
				amt_q     <= alu_res[31:0];
				report_q  <= report_c;
				largest_q <= '0;
				cnt_q     <= '0;
				prv_q     <= rover_q;
			end
			nfca_pkg::ST_A_ROV: blk_q <= rd_next;
			nfca_pkg::ST_A_HEAD: begin
				if (!nfca_pkg::is_desc(blk_q)) begin
					prv_q <= nfca_pkg::HEADP;
				end
				blk_q <= a_cur;
			end
			nfca_pkg::ST_A_EVAL: begin
				if (a_fit) begin
					blk_start_q <= rd_start;
					blk_next_q  <= rd_next;
					rem_q       <= alu_res[31:0];
					exact_q     <= (alu_res[31:0] == '0);
					link_q      <= rd_next;
				end else begin
					if (rd_len > largest_q) begin
						largest_q <= rd_len;
					end
					prv_q <= blk_q;
					blk_q <= rd_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			nfca_pkg::ST_T_REQ: begin
				if (!nfca_pkg::is_desc(spare_head_q)) begin
					r_q <= fresh_count_q;
				end
			end
			nfca_pkg::ST_T_WAIT: r_q <= spare_head_q;
			nfca_pkg::ST_A_SPLIT: link_q <= r_q;
			nfca_pkg::ST_F_START: begin
				prv_q <= nfca_pkg::NIL;
				blk_q <= used_head_q;
				cnt_q <= '0;
			end
			nfca_pkg::ST_F_EVAL: begin
				if (f_match) begin
					blk_start_q <= rd_start;
					blk_len_q   <= rd_len;
					blk_next_q  <= rd_next;
				end else begin
					prv_q <= blk_q;
					blk_q <= rd_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			nfca_pkg::ST_F_UNLINK: begin
				d_q         <= blk_q;
				ins_start_q <= blk_start_q;
				ins_len_q   <= blk_len_q;
			end
			nfca_pkg::ST_S_CHECK: amt_q <= alu_res[31:0];
			nfca_pkg::ST_S_REM:   rem_q <= alu_res[31:0];
			nfca_pkg::ST_S_SPLIT: begin
				d_q         <= r_q;
				ins_start_q <= alu_res[31:0];
				ins_len_q   <= rem_q;
			end
			nfca_pkg::ST_I_START: begin
				ins_end_q <= alu_res[31:0];
				prv_q     <= nfca_pkg::NIL;
				blk_q     <= free_head_q;
				cnt_q     <= '0;
			end
			nfca_pkg::ST_I_EVAL: begin
				if (alu_res[32]) begin
					prv_q <= blk_q;
					blk_q <= rd_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			nfca_pkg::ST_I_LINK: ins_next_q <= blk_q;
			nfca_pkg::ST_I_M1: begin
				if (adj1) begin
					ins_len_q  <= alu_res[31:0];
					ins_next_q <= rd_next;
				end
			end
			nfca_pkg::ST_I_M2E: pl_q <= rd_len;
			default: begin
			end
		endcase
	end

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != nfca_pkg::ST_IDLE))
		else $error("accepted transaction did not start the sequencer");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_count_q <= nfca_pkg::NIL)
		else $error("descriptor fresh count beyond table size");

	a_head_not_pseudo: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q != nfca_pkg::HEADP) && (rover_q != nfca_pkg::HEADP))
		else $error("free head or rover holds the head pseudo index");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !out_valid_q)
		else $error("result finished while previous result still pending");

	a_nonzero_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && fin_res != '0) |-> (fin_sts == nfca_pkg::STS_OK))
		else $error("nonzero result value with failure status");

endmodule
